FILE: design/fdp_pkg.sv
// Package for the format directive parser: phase type, codes and number helpers.
package fdp_pkg;

    // Width of the internal decimal accumulators (8 to 32).
    localparam int NumBits = 16;

    typedef logic [NumBits-1:0] num_t;

    typedef enum logic [3:0] {
        PH_START     = 4'd0,
        PH_AFTER_PCT = 4'd1,
        PH_WIDTH     = 4'd2,
        PH_WDIG      = 4'd3,
        PH_DOT       = 4'd4,
        PH_PREC      = 4'd5,
        PH_PDIG      = 4'd6,
        PH_LEN       = 4'd7,
        PH_LEN_L     = 4'd8,
        PH_LEN_H     = 4'd9,
        PH_SPEC      = 4'd10,
        PH_SKIP      = 4'd11
    } phase_t;

    // Flag codes
    localparam logic [2:0] FLAG_NONE  = 3'd0;
    localparam logic [2:0] FLAG_MINUS = 3'd1;
    localparam logic [2:0] FLAG_PLUS  = 3'd2;
    localparam logic [2:0] FLAG_HASH  = 3'd3;
    localparam logic [2:0] FLAG_ZERO  = 3'd4;

    // Width and precision kinds
    localparam logic [1:0] KIND_ABSENT  = 2'd0;
    localparam logic [1:0] KIND_LITERAL = 2'd1;
    localparam logic [1:0] KIND_ARG     = 2'd2;

    // Length codes
    localparam logic [3:0] LEN_NONE = 4'd0;
    localparam logic [3:0] LEN_L    = 4'd1;
    localparam logic [3:0] LEN_LL   = 4'd2;
    localparam logic [3:0] LEN_H    = 4'd3;
    localparam logic [3:0] LEN_HH   = 4'd4;
    localparam logic [3:0] LEN_J    = 4'd5;
    localparam logic [3:0] LEN_Z    = 4'd6;
    localparam logic [3:0] LEN_T    = 4'd7;
    localparam logic [3:0] LEN_BIG_L = 4'd8;

    // Characters
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOW_L   = 8'h6C;
    localparam logic [7:0] CH_LOW_H   = 8'h68;
    localparam logic [7:0] CH_LOW_J   = 8'h6A;
    localparam logic [7:0] CH_LOW_Z   = 8'h7A;
    localparam logic [7:0] CH_LOW_T   = 8'h74;
    localparam logic [7:0] CH_BIG_L   = 8'h4C;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic [3:0] digit_value(input logic [7:0] b);
        logic [7:0] d;
        d = b - CH_ZERO;
        return d[3:0];
    endfunction

    // v * 10 + d, saturated at the all-ones value of num_t
    function automatic num_t accumulate(input num_t v, input logic [3:0] d);
        logic [NumBits+3:0] n;
        n = ({4'b0, v} << 3) + ({4'b0, v} << 1) + (NumBits+4)'(d);
        if (n[NumBits+3:NumBits] != 4'b0) begin
            return '1;
        end
        return n[NumBits-1:0];
    endfunction

    // Reduce an accumulator to the 16-bit result field
    function automatic logic [15:0] to_field(input num_t v);
        logic [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

endpackage

FILE: design/format_directive_parser_unit.sv
// Top level: printf-style directive parser, one byte per cycle while no result stalls.
//
// Usage:
//   Input channel (s_): one format byte per word plus s_end_of_view on the
//   last byte of a text view. Each view yields at most one result word on
//   the m_ channel: the parsed directive fields, or m_status = 1 with all
//   other fields zero for a malformed or truncated directive.
//   The result word is registered: m_valid rises in the cycle after the byte that
//   completes the directive (specifier byte or error) is accepted.
//   Throughput: one byte per cycle unless a result stalls; the per-byte decode and the
//   multiply-by-ten accumulator sit between the phase and held-field registers
//   and the result register, so a new byte is taken every cycle s_ready is high.
//   Bytes after a result are dropped up to the view's last byte.
//   Stall: s_ready stays high while the result register is empty or being
//   taken; while a result waits with m_ready low, s_ready is low and the
//   parser holds its state.
//   Reset (aresetn low, synchronous): the parser expects '%' at the start
//   of a view, all held fields clear and no result is pending.
module format_directive_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_end_of_view,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status,
    output logic [2:0]  m_flag_code,
    output logic [1:0]  m_width_kind,
    output logic [15:0] m_width_value,
    output logic [1:0]  m_precision_kind,
    output logic [15:0] m_precision_value,
    output logic [3:0]  m_length_code,
    output logic [7:0]  m_conversion_char,
    output logic [7:0]  m_bytes_consumed
);
    import fdp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [2:0]  flag_reg, flag_next;
    num_t        width_reg, width_next;
    logic [1:0]  wkind_reg, wkind_next;
    num_t        prec_reg, prec_next;
    logic [1:0]  pkind_reg, pkind_next;
    logic [3:0]  len_reg, len_next;
    logic [7:0]  count_reg, count_next;

    logic        emit, emit_err;
    logic [7:0]  emit_spec;
    logic        consumed;
    logic        accept;

    logic        m_valid_reg;
    logic        status_reg, status_next;
    logic [2:0]  flag_out_reg, flag_out_next;
    logic [1:0]  wkind_out_reg, wkind_out_next;
    logic [15:0] width_out_reg, width_out_next;
    logic [1:0]  pkind_out_reg, pkind_out_next;
    logic [15:0] prec_out_reg, prec_out_next;
    logic [3:0]  len_out_reg, len_out_next;
    logic [7:0]  conv_out_reg, conv_out_next;
    logic [7:0]  count_out_reg, count_out_next;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Next phase and held fields for the byte on the input
    always_comb begin
        phase_next = phase_reg;
        flag_next  = flag_reg;
        width_next = width_reg;
        wkind_next = wkind_reg;
        prec_next  = prec_reg;
        pkind_next = pkind_reg;
        len_next   = len_reg;
        count_next = count_reg;
        emit       = 1'b0;
        emit_err   = 1'b0;
        emit_spec  = 8'd0;
        consumed   = 1'b0;
        case (phase_reg)
            PH_SKIP: begin
                if (s_end_of_view) begin
                    phase_next = PH_START;
                end
            end
            PH_START: begin
                flag_next  = FLAG_NONE;
                width_next = '0;
                wkind_next = KIND_ABSENT;
                prec_next  = '0;
                pkind_next = KIND_ABSENT;
                len_next   = LEN_NONE;
                if (s_in_byte != CH_PERCENT) begin
                    count_next = 8'd0;
                    emit       = 1'b1;
                    emit_err   = 1'b1;
                end else begin
                    count_next = 8'd1;
                    phase_next = PH_AFTER_PCT;
                    if (s_end_of_view) begin
                        emit     = 1'b1;
                        emit_err = 1'b1;
                    end
                end
            end
            default: begin
                if (count_reg != 8'hFF) begin
                    count_next = count_reg + 8'd1;
                end
                // Walk the stages in order; a byte not taken falls to the next
                if (phase_next == PH_AFTER_PCT) begin
                    if (s_in_byte == CH_PERCENT) begin
                        emit      = 1'b1;
                        emit_spec = CH_PERCENT;
                        consumed  = 1'b1;
                    end else begin
                        phase_next = PH_WIDTH;
                        consumed   = 1'b1;
                        if (s_in_byte == CH_MINUS)      flag_next = FLAG_MINUS;
                        else if (s_in_byte == CH_PLUS)  flag_next = FLAG_PLUS;
                        else if (s_in_byte == CH_HASH)  flag_next = FLAG_HASH;
                        else if (s_in_byte == CH_ZERO)  flag_next = FLAG_ZERO;
                        else                            consumed  = 1'b0;
                    end
                end
                if (!consumed && phase_next == PH_WIDTH) begin
                    if (is_digit(s_in_byte)) begin
                        wkind_next = KIND_LITERAL;
                        width_next = num_t'(digit_value(s_in_byte));
                        phase_next = PH_WDIG;
                        consumed   = 1'b1;
                    end else if (s_in_byte == CH_STAR) begin
                        wkind_next = KIND_ARG;
                        phase_next = PH_DOT;
                        consumed   = 1'b1;
                    end else begin
                        phase_next = PH_DOT;
                    end
                end
                if (!consumed && phase_next == PH_WDIG) begin
                    if (is_digit(s_in_byte)) begin
                        width_next = accumulate(width_reg, digit_value(s_in_byte));
                        consumed   = 1'b1;
                    end else begin
                        phase_next = PH_DOT;
                    end
                end
                if (!consumed && phase_next == PH_DOT) begin
                    if (s_in_byte == CH_DOT) begin
                        phase_next = PH_PREC;
                        consumed   = 1'b1;
                    end else begin
                        phase_next = PH_LEN;
                    end
                end
                if (!consumed && phase_next == PH_PREC) begin
                    if (is_digit(s_in_byte)) begin
                        pkind_next = KIND_LITERAL;
                        prec_next  = num_t'(digit_value(s_in_byte));
                        phase_next = PH_PDIG;
                        consumed   = 1'b1;
                    end else if (s_in_byte == CH_STAR) begin
                        pkind_next = KIND_ARG;
                        phase_next = PH_LEN;
                        consumed   = 1'b1;
                    end else begin
                        // bare '.' means literal zero precision
                        pkind_next = KIND_LITERAL;
                        prec_next  = '0;
                        phase_next = PH_LEN;
                    end
                end
                if (!consumed && phase_next == PH_PDIG) begin
                    if (is_digit(s_in_byte)) begin
                        prec_next = accumulate(prec_reg, digit_value(s_in_byte));
                        consumed  = 1'b1;
                    end else begin
                        phase_next = PH_LEN;
                    end
                end
                if (!consumed && phase_next == PH_LEN) begin
                    phase_next = PH_SPEC;
                    consumed   = 1'b1;
                    if (s_in_byte == CH_LOW_L)       phase_next = PH_LEN_L;
                    else if (s_in_byte == CH_LOW_H)  phase_next = PH_LEN_H;
                    else if (s_in_byte == CH_LOW_J)  len_next   = LEN_J;
                    else if (s_in_byte == CH_LOW_Z)  len_next   = LEN_Z;
                    else if (s_in_byte == CH_LOW_T)  len_next   = LEN_T;
                    else if (s_in_byte == CH_BIG_L)  len_next   = LEN_BIG_L;
                    else                             consumed   = 1'b0;
                end
                if (!consumed && phase_next == PH_LEN_L) begin
                    phase_next = PH_SPEC;
                    if (s_in_byte == CH_LOW_L) begin
                        len_next = LEN_LL;
                        consumed = 1'b1;
                    end else begin
                        len_next = LEN_L;
                    end
                end
                if (!consumed && phase_next == PH_LEN_H) begin
                    phase_next = PH_SPEC;
                    if (s_in_byte == CH_LOW_H) begin
                        len_next = LEN_HH;
                        consumed = 1'b1;
                    end else begin
                        len_next = LEN_H;
                    end
                end
                if (!consumed && phase_next == PH_SPEC) begin
                    emit      = 1'b1;
                    emit_spec = s_in_byte;
                end
                // Truncated directive: view ended before the specifier
                if (!emit && s_end_of_view) begin
                    emit     = 1'b1;
                    emit_err = 1'b1;
                end
            end
        endcase
        if (emit) begin
            phase_next = s_end_of_view ? PH_START : PH_SKIP;
        end
    end

    // Result word fields
    always_comb begin
        status_next    = emit_err;
        flag_out_next  = 3'd0;
        wkind_out_next = 2'd0;
        width_out_next = 16'd0;
        pkind_out_next = 2'd0;
        prec_out_next  = 16'd0;
        len_out_next   = 4'd0;
        conv_out_next  = 8'd0;
        count_out_next = 8'd0;
        if (!emit_err) begin
            flag_out_next  = flag_next;
            wkind_out_next = wkind_next;
            width_out_next = (wkind_next == KIND_LITERAL) ? to_field(width_next) : 16'd0;
            pkind_out_next = pkind_next;
            prec_out_next  = (pkind_next == KIND_LITERAL) ? to_field(prec_next) : 16'd0;
            len_out_next   = len_next;
            conv_out_next  = emit_spec;
            count_out_next = count_next;
        end
    end

    // Advance the parser state on each accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            flag_reg  <= FLAG_NONE;
            width_reg <= '0;
            wkind_reg <= KIND_ABSENT;
            prec_reg  <= '0;
            pkind_reg <= KIND_ABSENT;
            len_reg   <= LEN_NONE;
            count_reg <= 8'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            flag_reg  <= flag_next;
            width_reg <= width_next;
            wkind_reg <= wkind_next;
            prec_reg  <= prec_next;
            pkind_reg <= pkind_next;
            len_reg   <= len_next;
            count_reg <= count_next;
        end
    end

    // Hold the result word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept && emit) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    // Load the result payload
    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            status_reg    <= status_next;
            flag_out_reg  <= flag_out_next;
            wkind_out_reg <= wkind_out_next;
            width_out_reg <= width_out_next;
            pkind_out_reg <= pkind_out_next;
            prec_out_reg  <= prec_out_next;
            len_out_reg   <= len_out_next;
            conv_out_reg  <= conv_out_next;
            count_out_reg <= count_out_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = status_reg;
    assign m_flag_code       = flag_out_reg;
    assign m_width_kind      = wkind_out_reg;
    assign m_width_value     = width_out_reg;
    assign m_precision_kind  = pkind_out_reg;
    assign m_precision_value = prec_out_reg;
    assign m_length_code     = len_out_reg;
    assign m_conversion_char = conv_out_reg;
    assign m_bytes_consumed  = count_out_reg;

endmodule
